@@ sv/sphk_pkg.sv @@
// shared types and constants for the sph kernel weighted average block
package sphk_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned QueueDepth    = 2;
  localparam logic [23:0] RadiusReset   = 24'd65536;

  // one neighbour after weighting, handed from front to back
  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [16:0] w;
    logic        last;
  } entry_t;

endpackage

@@ sv/sph_kernel_weighted_average.sv @@
// top level of the sph cubic spline kernel weighted average
//
// Input channel: one neighbour per transfer (value_x/y/z, distance, has_neighbour,
// last_neighbour), valid/stall handshake. Output channel: one result per group,
// sent after the transfer with last_neighbour. kernel_radius resets to 1.0 (Q8.16).
// Write it via cfg_we_i/cfg_wdata_i only while the block is idle; nothing enforces it.
// Front part: an 18-step restoring divider forms q = distance / radius, then two
// multiply steps, square and cube, build the spline weight; a neighbour whose
// weight is known to be zero skips both. The front stalls its input from accepting
// a neighbour until it has pushed that one into the queue. A two-entry queue feeds
// the back part, which multiplies and accumulates each neighbour (B_MAC, B_ACC)
// and, on the last one of a group, runs three parallel 32-step dividers that
// form the rounded averages. Reset clears the accumulators, the queue and all
// valid flags. While the receiver stalls, the result stays in the output register;
// the back part keeps accumulating the next group and waits only when a further
// result is ready.
module sph_kernel_weighted_average
  import sphk_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_x_i,
  input  logic [31:0] value_y_i,
  input  logic [31:0] value_z_i,
  input  logic [23:0] distance_i,
  input  logic        has_neighbour_i,
  input  logic        last_neighbour_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] avg_x_o,
  output logic [31:0] avg_y_o,
  output logic [31:0] avg_z_o,
  output logic        had_weight_o
);

  logic [23:0] radius_q;
  logic        push, full, pop, empty;
  entry_t      push_data, pop_data;

  // radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  sphk_front u_front (
    .clk_i, .rst_ni,
    .radius_i(radius_q),
    .in_valid_i, .in_stall_o,
    .value_x_i, .value_y_i, .value_z_i, .distance_i,
    .has_neighbour_i, .last_neighbour_i,
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  sphk_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_data), .empty_o(empty)
  );

  sphk_back #(.ValueWidth(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .pop_data_i(pop_data), .pop_o(pop),
    .out_valid_o, .out_stall_i,
    .avg_x_o, .avg_y_o, .avg_z_o, .had_weight_o
  );

endmodule

@@ sv/sphk_front.sv @@
// front part: takes neighbours, divides distance by radius, computes the spline weight
module sphk_front
  import sphk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [23:0] radius_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_x_i,
  input  logic [31:0] value_y_i,
  input  logic [31:0] value_z_i,
  input  logic [23:0] distance_i,
  input  logic        has_neighbour_i,
  input  logic        last_neighbour_i,
  output logic        push_o,
  output entry_t      push_data_o,
  input  logic        full_i
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DIV  = 5'b00010,
    F_SQR  = 5'b00100,
    F_CUBE = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_e;

  fstate_e     state_q, state_d;
  logic [31:0] vx_q, vy_q, vz_q;
  logic        last_q;
  logic [23:0] d_q, h_q;
  logic [23:0] rem_q, rem_d;
  logic [17:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        zero_q, zero_d;
  logic        near_q, near_d;
  logic [16:0] a_q, a_d;
  logic [33:0] sq_q, sq_d;
  logic [50:0] cube_q, cube_d;

  logic        accept;
  logic        dbit;
  logic [24:0] trial;
  logic [17:0] far_t;
  logic [52:0] num;
  logic [52:0] rnd;

  assign accept     = in_valid_i && (state_q == F_IDLE);
  assign in_stall_o = (state_q != F_IDLE);

  // next dividend bit: two distance bits, then the zeros of the shift
  assign dbit  = (cnt_q == 5'd17) ? d_q[1] : ((cnt_q == 5'd16) ? d_q[0] : 1'b0);
  assign trial = {rem_q, dbit};
  assign far_t = 18'd131072 - quo_q;

  // weight in q.50, then rounded to q.16
  always_comb begin
    if (near_q) begin
      num = 53'd1 << 50;
      num = num + 53'(3 * 53'(cube_q)) - (53'(6 * 53'(sq_q)) << 16);
    end else begin
      num = 53'(cube_q);
    end
    rnd = num + (53'd1 << 33);
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    zero_d  = zero_q;
    near_d  = near_q;
    a_d     = a_q;
    sq_d    = sq_q;
    cube_d  = cube_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          zero_d = !has_neighbour_i || (radius_i == 24'd0) ||
                   ({2'b00, distance_i} >= {radius_i, 2'b00});
          rem_d  = {2'b00, distance_i[23:2]};
          quo_d  = '0;
          cnt_d  = 5'd17;
          state_d = zero_d ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (trial >= {1'b0, h_q}) begin
          rem_d = 24'(trial - {1'b0, h_q});
          quo_d = {quo_q[16:0], 1'b1};
        end else begin
          rem_d = trial[23:0];
          quo_d = {quo_q[16:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) state_d = F_SQR;
      end
      F_SQR: begin
        if (quo_q > 18'd131072) begin
          zero_d  = 1'b1;
          state_d = F_PUSH;
        end else begin
          near_d  = (quo_q <= 18'd65536);
          a_d     = near_d ? quo_q[16:0] : far_t[16:0];
          sq_d    = 34'(a_d) * 34'(a_d);
          state_d = F_CUBE;
        end
      end
      F_CUBE: begin
        cube_d  = 51'(sq_q) * 51'(a_q);
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign push_o         = (state_q == F_PUSH) && !full_i;
  assign push_data_o.vx = vx_q;
  assign push_data_o.vy = vy_q;
  assign push_data_o.vz = vz_q;
  assign push_data_o.w  = zero_q ? 17'd0 : rnd[50:34];
  assign push_data_o.last = last_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vx_q   <= value_x_i;
      vy_q   <= value_y_i;
      vz_q   <= value_z_i;
      last_q <= last_neighbour_i;
      d_q    <= distance_i;
      h_q    <= radius_i;
    end
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    zero_q <= zero_d;
    near_q <= near_d;
    a_q    <= a_d;
    sq_q   <= sq_d;
    cube_q <= cube_d;
  end

endmodule

@@ sv/sphk_fifo.sv @@
// short queue between the front and back parts
module sphk_fifo
  import sphk_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t pop_data_o,
  output logic   empty_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  entry_t        mem_q [Depth];
  logic [Aw-1:0] wptr_q, rptr_q;
  logic [Aw:0]   cnt_q;

  assign full_o     = (cnt_q == (Aw+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + Aw'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + Aw'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (Aw+1)'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - (Aw+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

endmodule

@@ sv/sphk_back.sv @@
// back part: accumulates weighted sums and divides them out at the end of a group
module sphk_back
  import sphk_pkg::*;
#(
  parameter int unsigned ValueWidth = ValueWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  entry_t      pop_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] avg_x_o,
  output logic [31:0] avg_y_o,
  output logic [31:0] avg_z_o,
  output logic        had_weight_o
);

  localparam int unsigned Vw = (ValueWidth > 32) ? 32 : ((ValueWidth < 2) ? 2 : ValueWidth);
  localparam int unsigned Sh = 32 - Vw;
  localparam logic signed [32:0] Hi   = (33'sd1 <<< (Vw - 1)) - 33'sd1;
  localparam logic signed [32:0] Lo   = -Hi - 33'sd1;
  localparam logic        [32:0] Mask = (33'd1 << Vw) - 33'd1;
  localparam logic signed [53:0] SumMax = (54'sd1 <<< 52) - 54'sd1;
  localparam logic signed [53:0] SumMin = -(54'sd1 <<< 52);
  localparam logic        [21:0] WtMax  = '1;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MAC  = 6'b000010,
    B_ACC  = 6'b000100,
    B_PREP = 6'b001000,
    B_DIV  = 6'b010000,
    B_FIN  = 6'b100000
  } bstate_e;

  bstate_e            state_q, state_d;
  entry_t             ent_q;
  logic signed [49:0] prod_q [3];
  logic signed [52:0] sum_q  [3];
  logic [21:0]        wt_q;
  logic [23:0]        rem_q  [3];
  logic [31:0]        numl_q [3];
  logic [31:0]        quo_q  [3];
  logic [2:0]         neg_q, ovf_q;
  logic [4:0]         cnt_q;
  logic               out_valid_q;
  logic [31:0]        avg_q  [3];
  logic               had_q;

  logic signed [31:0] val    [3];
  logic [22:0]        den;
  logic               out_free;
  logic [22:0]        wt_sum;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign den      = {wt_q, 1'b0};
  assign wt_sum   = {1'b0, wt_q} + 23'(ent_q.w);

  // values reduced to the configured signed width
  assign val[0] = $signed(ent_q.vx << Sh) >>> Sh;
  assign val[1] = $signed(ent_q.vy << Sh) >>> Sh;
  assign val[2] = $signed(ent_q.vz << Sh) >>> Sh;

  function automatic logic signed [52:0] sat_add(logic signed [52:0] a,
                                                 logic signed [49:0] b);
    logic signed [53:0] s;
    s = 54'(a) + 54'(b);
    if (s > SumMax) return SumMax[52:0];
    if (s < SumMin) return SumMin[52:0];
    return s[52:0];
  endfunction

  function automatic logic [31:0] finish(logic neg, logic ovf, logic [31:0] qm);
    logic signed [32:0] r;
    if (neg) begin
      if (ovf || ({1'b0, qm} > 33'(Hi + 33'sd1))) r = Lo;
      else r = -$signed({1'b0, qm});
    end else begin
      if (ovf || ({1'b0, qm} > 33'(Hi))) r = Hi;
      else r = $signed({1'b0, qm});
    end
    return r[31:0] & Mask[31:0];
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!empty_i) state_d = B_MAC;
      B_MAC:  state_d = B_ACC;
      B_ACC:  state_d = ent_q.last ? B_PREP : B_IDLE;
      B_PREP: state_d = (wt_q == '0) ? B_FIN : B_DIV;
      B_DIV:  if (cnt_q == 5'd0) state_d = B_FIN;
      B_FIN:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      wt_q        <= '0;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_FIN && out_free) begin
        out_valid_q <= 1'b1;
        wt_q        <= '0;
        for (int i = 0; i < 3; i++) sum_q[i] <= '0;
      end else begin
        if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
        if (state_q == B_ACC) begin
          wt_q <= (wt_sum > {1'b0, WtMax}) ? WtMax : wt_sum[21:0];
          for (int i = 0; i < 3; i++) sum_q[i] <= sat_add(sum_q[i], prod_q[i]);
        end
      end
    end
  end

  // datapath: products, division lanes, output registers
  always_ff @(posedge clk_i) begin
    logic [52:0] mag;
    logic [53:0] n;
    logic [24:0] tr;
    if (pop_o) ent_q <= pop_data_i;
    if (state_q == B_MAC) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= 50'(val[i]) * 50'($signed({1'b0, ent_q.w}));
      end
    end
    if (state_q == B_PREP) begin
      cnt_q <= 5'd31;
      for (int i = 0; i < 3; i++) begin
        neg_q[i]  <= sum_q[i][52];
        mag        = sum_q[i][52] ? 53'(-sum_q[i]) : 53'(sum_q[i]);
        n          = {mag, 1'b0} + 54'(wt_q);
        ovf_q[i]  <= ({1'b0, n} >= {den, 32'd0});
        rem_q[i]  <= 24'(n[53:32]);
        numl_q[i] <= n[31:0];
        quo_q[i]  <= '0;
      end
    end
    if (state_q == B_DIV) begin
      cnt_q <= cnt_q - 5'd1;
      for (int i = 0; i < 3; i++) begin
        tr = {rem_q[i], numl_q[i][31]};
        numl_q[i] <= {numl_q[i][30:0], 1'b0};
        if (tr >= {2'b00, den}) begin
          rem_q[i] <= 24'(tr - {2'b00, den});
          quo_q[i] <= {quo_q[i][30:0], 1'b1};
        end else begin
          rem_q[i] <= tr[23:0];
          quo_q[i] <= {quo_q[i][30:0], 1'b0};
        end
      end
    end
    if (state_q == B_FIN && out_free) begin
      had_q <= (wt_q != '0);
      for (int i = 0; i < 3; i++) begin
        avg_q[i] <= (wt_q == '0) ? 32'd0 : finish(neg_q[i], ovf_q[i], quo_q[i]);
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign avg_x_o      = avg_q[0];
  assign avg_y_o      = avg_q[1];
  assign avg_z_o      = avg_q[2];
  assign had_weight_o = had_q;

endmodule

@@ sv/sphk_checker.sv @@
// port-level checks for the sph kernel weighted average, bound to the top level
module sphk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] avg_x_o,
  input logic [31:0] avg_y_o,
  input logic [31:0] avg_z_o,
  input logic        had_weight_o
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(avg_x_o) &&
      $stable(avg_y_o) && $stable(avg_z_o) && $stable(had_weight_o)))
    else $error("result changed while stalled");

  // a group without weight gives zero averages
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !had_weight_o) |->
      (avg_x_o == 32'd0 && avg_y_o == 32'd0 && avg_z_o == 32'd0))
    else $error("nonzero average without weight");

  // front takes one neighbour at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("front accepted while busy");

endmodule

bind sph_kernel_weighted_average sphk_checker u_sphk_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .avg_x_o, .avg_y_o, .avg_z_o, .had_weight_o
);

@@ verif/tb_top.sv @@
// self-checking testbench for the sph kernel weighted average block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CycleLimit = 600000;
  localparam int unsigned     SettleCycles = 120;
  localparam longint          SumMax = (64'sd1 <<< 52) - 1;
  localparam longint          SumMin = -SumMax - 1;
  localparam longint unsigned WeightMax = (64'd1 << 22) - 1;
  localparam logic [23:0]     MaxDistance = 24'hFFFFFF;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [23:0] distance;
    logic        has;
    logic        last;
  } neighbour_t;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic        had;
  } average_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [23:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] value_x_i = '0;
  logic [31:0] value_y_i = '0;
  logic [31:0] value_z_i = '0;
  logic [23:0] distance_i = '0;
  logic        has_neighbour_i = 1'b0;
  logic        last_neighbour_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] avg_x_o;
  logic [31:0] avg_y_o;
  logic [31:0] avg_z_o;
  logic        had_weight_o;

  sph_kernel_weighted_average dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_x_i       (value_x_i),
    .value_y_i       (value_y_i),
    .value_z_i       (value_z_i),
    .distance_i      (distance_i),
    .has_neighbour_i (has_neighbour_i),
    .last_neighbour_i(last_neighbour_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .avg_x_o         (avg_x_o),
    .avg_y_o         (avg_y_o),
    .avg_z_o         (avg_z_o),
    .had_weight_o    (had_weight_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  neighbour_t      pending_q[$];
  average_t        averages_q[$];
  logic [23:0]     radius_m = sphk_pkg::RadiusReset;
  longint          acc_x = 0, acc_y = 0, acc_z = 0;
  longint unsigned acc_w = 0;
  int unsigned     errors = 0;
  longint unsigned cycle = 0;
  int unsigned     in_gap = 0;
  int unsigned     out_gap = 0;
  int unsigned     hold_left = 0;
  bit              hold_done = 1'b0;

  // append one neighbour to the pending stimulus
  function automatic void add_item(neighbour_t n);
    pending_q = {pending_q, n};
  endfunction

  // cubic spline weight in Q1.16
  function automatic longint unsigned spline_weight(logic [23:0] d, logic [23:0] h);
    longint unsigned q, q2, q3, t, num;
    if (h == 0) return 0;
    q = ({40'd0, d} << 16) / {40'd0, h};
    if (q > 64'd131072) return 0;
    if (q <= 64'd65536) begin
      q2 = q * q;
      q3 = q2 * q;
      num = (64'd1 << 50) + 3 * q3 - ((6 * q2) << 16);
    end else begin
      t = 64'd131072 - q;
      num = t * t * t;
    end
    return (num + (64'd1 << 33)) >> 34;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SumMax) return SumMax;
    if (s < SumMin) return SumMin;
    return s;
  endfunction

  // rounded ratio, ties away from zero, saturated to 32 bits
  function automatic logic [31:0] ratio(longint s, longint unsigned w);
    longint unsigned mag, qm;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    qm = (2 * mag + w) / (2 * w);
    if (s < 0) return (qm > 64'd2147483648) ? 32'h8000_0000 : 32'(-longint'(qm));
    return (qm > 64'd2147483647) ? 32'h7FFF_FFFF : 32'(qm);
  endfunction

  // fold one accepted neighbour into the running group sums
  function automatic void accumulate_neighbour(neighbour_t n);
    longint unsigned w;
    average_t r;
    if (n.has) begin
      w = spline_weight(n.distance, radius_m);
      if (w != 0) begin
        acc_x = sat_sum(acc_x, longint'($signed(n.vx)) * longint'(w));
        acc_y = sat_sum(acc_y, longint'($signed(n.vy)) * longint'(w));
        acc_z = sat_sum(acc_z, longint'($signed(n.vz)) * longint'(w));
        acc_w = (acc_w + w > WeightMax) ? WeightMax : acc_w + w;
      end
    end
    if (!n.last) return;
    if (acc_w == 0) r = '0;
    else r = '{ratio(acc_x, acc_w), ratio(acc_y, acc_w), ratio(acc_z, acc_w), 1'b1};
    averages_q = {averages_q, r};
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    acc_w = 0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((cycle / 500) % 4 == 1) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // input driver: transfer on valid and no stall, then offer next item or idle
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      accumulate_neighbour(pending_q.pop_front());
      in_gap = pick_gap();
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (in_gap > 0 || pending_q.size() == 0 || !rst_ni) begin
        if (in_gap > 0) in_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i       <= 1'b1;
        value_x_i        <= pending_q[0].vx;
        value_y_i        <= pending_q[0].vy;
        value_z_i        <= pending_q[0].vz;
        distance_i       <= pending_q[0].distance;
        has_neighbour_i  <= pending_q[0].has;
        last_neighbour_i <= pending_q[0].last;
      end
    end
  end

  // output monitor: compare each transfer with the oldest expected average
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (averages_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h had=%b", $realtime,
                 avg_x_o, avg_y_o, avg_z_o, had_weight_o);
        errors++;
      end else begin
        average_t e;
        e = averages_q.pop_front();
        if ({avg_x_o, avg_y_o, avg_z_o, had_weight_o} !== e) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h had=%b, got x=%h y=%h z=%h had=%b",
                   $realtime, e.ax, e.ay, e.az, e.had, avg_x_o, avg_y_o, avg_z_o,
                   had_weight_o);
          errors++;
        end
      end
    end
  end

  // receiver stall, with one long hold-off while items keep coming
  always @(posedge clk_i) begin
    if (!hold_done && cycle == 4000) begin
      hold_done = 1'b1;
      hold_left = 1500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_gap = pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle++;
    if (cycle > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 131072)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic neighbour_t near_item(logic [23:0] h, bit last);
    neighbour_t n;
    longint unsigned span;
    span = 2 * longint'(h) + longint'(h) / 4 + 2;
    if (span > MaxDistance) span = MaxDistance;
    n.vx = pick_value();
    n.vy = pick_value();
    n.vz = pick_value();
    n.distance = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                             : 24'($urandom_range(0, 32'(span)));
    n.has = ($urandom_range(0, 19) != 0);
    n.last = last;
    return n;
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || averages_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_radius(logic [23:0] h);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= h;
    radius_m = h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random groups, mostly short, a few long enough to saturate the sums
  task automatic random_groups(logic [23:0] h, int unsigned count);
    int unsigned n, len;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(40, 75) : $urandom_range(1, 6);
      for (int unsigned i = 0; i < len; i++)
        add_item(near_item(h, i == len - 1));
      n += len;
    end
  endtask

  logic [23:0] radii[6];

  // stimulus
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: exact q of 0, 1, 2 and beyond, extremes, absent neighbours
    add_item('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 24'd0, 1'b1, 1'b1});
    add_item('{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'd65536, 1'b1, 1'b0});
    add_item('{32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0001, 24'd131072, 1'b1, 1'b0});
    add_item('{32'h1234_5678, 32'h0, 32'h0, 24'd131073, 1'b1, 1'b0});
    add_item('{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 24'd98304, 1'b1, 1'b1});
    add_item('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b1, 1'b1});
    add_item('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 24'd0, 1'b0, 1'b0});
    add_item('{32'h0, 32'h0, 32'h0, 24'd0, 1'b0, 1'b1});
    add_item('{32'hFFFF_0000, 32'h0002_0000, 32'h8000_0001, 24'd32768, 1'b1, 1'b0});
    add_item('{32'h0001_0000, 32'hFFFE_0000, 32'h7FFF_FFFE, 24'd40000, 1'b0, 1'b0});
    add_item('{32'h0000_0005, 32'h0000_0007, 32'hFFFF_FFF9, 24'd120000, 1'b1, 1'b1});
    add_item('{32'hFFFF_FFFF, 32'h0, 32'h1, 24'd131000, 1'b1, 1'b1});

    // zero radius, then small, large and random radii
    set_radius(24'd0);
    add_item('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'd0, 1'b1, 1'b1});
    random_groups(24'd0, 10);

    radii = '{24'd1, 24'hFFFFFF, 24'd65536, 24'($urandom_range(2, 4096)),
              24'($urandom_range(20000, 300000)), 24'($urandom)};
    foreach (radii[i]) begin
      set_radius(radii[i]);
      random_groups(radii[i], 210);
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
